[hdl/srw_osc_pkg.sv]
// Shared types, constants and the quarter-wave cosine table of the random-wave oscillator.
// Used by the channel interfaces and the top level; depends on nothing else.
package srw_osc_pkg;

   // Table size and precision of the blend weight
   localparam int COS_TABLE_DEPTH = 1024;
   localparam int COS_DEPTH_LOG2  = $clog2(COS_TABLE_DEPTH);
   localparam int SAMPLE_BITS     = 16;
   localparam int FRAC_BITS       = SAMPLE_BITS - 1;

   // Field widths
   localparam int FREQ_W   = 16;
   localparam int SMOOTH_W = 17;
   localparam int LEVEL_W  = 16;
   localparam int OUT_W    = 16;
   localparam int SCALE_W  = 32;
   localparam int PHASE_W  = 26;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_NYQUIST    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SCALE = CSR_IDX_W'(1);
   localparam logic [FREQ_W-1:0]    NYQUIST_RESET  = FREQ_W'(22050);
   localparam logic [SCALE_W-1:0]   SCALE_RESET    = SCALE_W'(194783);

   // Item commands
   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_NOTE_ON = 1'b1;

   // Phase and smoothness constants
   localparam logic [PHASE_W-1:0]  ONE_PHASE  = PHASE_W'(1) << 24;
   localparam logic [PHASE_W-1:0]  PHASE_MAX  = {PHASE_W{1'b1}};
   localparam logic [SMOOTH_W-1:0] SMOOTH_ONE = SMOOTH_W'(65536);

   // Weight: signed, one bit above the table width
   localparam int W_W = SAMPLE_BITS + 1;
   localparam logic signed [W_W-1:0] W_POS = W_W'(1) << FRAC_BITS;
   localparam logic signed [W_W-1:0] W_NEG = -(W_W'(1) << FRAC_BITS);

   // Table indexing
   localparam int ROM_AW = $clog2(COS_TABLE_DEPTH + 1);
   localparam int D2     = 2 * COS_TABLE_DEPTH;
   localparam int D2_W   = $clog2(D2 + 1);

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Taylor series divisors (2n-1)*(2n) for n = 1..12
   localparam longint unsigned TAYLOR_DIV [1:12] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
      64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
   };

   typedef logic [SAMPLE_BITS-1:0] cos_rom_type [0:COS_TABLE_DEPTH];

   // Quarter-wave cosine, Taylor series to x^24 in Q.30, rounded to Q.FRAC_BITS
   function automatic cos_rom_type build_cos_rom();
      cos_rom_type       rom;
      longint unsigned   a;
      longint unsigned   a2;
      longint unsigned   term;
      longint unsigned   v;
      longint            acc;
      int                sh;
      sh = 31 - SAMPLE_BITS;
      for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
         a    = (HALF_PI_Q30 * longint'(k)) >> COS_DEPTH_LOG2;
         a2   = (a * a) >> 30;
         term = 64'd1 << 30;
         acc  = longint'(term);
         for (int n = 1; n <= 12; n++) begin
            term = ((term * a2) >> 30) / TAYLOR_DIV[n];
            if (n[0]) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         v      = (longint'(acc) + (64'd1 << (sh - 1))) >> sh;
         rom[k] = SAMPLE_BITS'(v);
      end
      return rom;
   endfunction

   localparam cos_rom_type COS_ROM = build_cos_rom();

endpackage

[hdl/srw_req_if.sv]
// Input channel of the random-wave oscillator: valid/ready plus one item's fields.
// Depends on srw_osc_pkg.
interface srw_req_if
   import srw_osc_pkg::*;
   ;
   logic                       valid;
   logic                       ready;
   logic                       cmd;
   logic [FREQ_W-1:0]          freq_hz;
   logic [SMOOTH_W-1:0]        smoothness;
   logic signed [LEVEL_W-1:0]  random_a;
   logic signed [LEVEL_W-1:0]  random_b;

   modport source (output valid, cmd, freq_hz, smoothness, random_a, random_b, input ready);
   modport sink   (input valid, cmd, freq_hz, smoothness, random_a, random_b, output ready);
endinterface

[hdl/srw_rsp_if.sv]
// Result channel of the random-wave oscillator: valid/ready plus the output sample.
// Depends on srw_osc_pkg.
interface srw_rsp_if
   import srw_osc_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic signed [OUT_W-1:0]  sample;

   modport source (output valid, sample, input ready);
   modport sink   (input valid, sample, output ready);
endinterface

[hdl/smoothed_random_wave_osc_unit.sv]
// Random-wave oscillator: a small sequencer around one restoring divider and one multiplier.
// Depends on srw_osc_pkg, srw_req_if and srw_rsp_if.
// A tick runs prep, then (cosine segment only) 25 one-bit restoring division steps, index,
//   table read and weight select, then both multiplies and finish, which hands off the sample.
// Ready only in idle, so a tick holds off the next item until then; a note-on beat stays idle.
// Reset (synchronous, active high) clears phase and levels and loads the register defaults.
module smoothed_random_wave_osc_unit
   import srw_osc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   srw_req_if.sink                 req_if,
   srw_rsp_if.source               rsp_if,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   // Sequencer codes
   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
   localparam logic [ST_W-1:0] ST_PREP = 4'd1;
   localparam logic [ST_W-1:0] ST_DIV  = 4'd2;
   localparam logic [ST_W-1:0] ST_IDX  = 4'd3;
   localparam logic [ST_W-1:0] ST_ROM  = 4'd4;
   localparam logic [ST_W-1:0] ST_WSEL = 4'd5;
   localparam logic [ST_W-1:0] ST_MULW = 4'd6;
   localparam logic [ST_W-1:0] ST_MULS = 4'd7;
   localparam logic [ST_W-1:0] ST_FIN  = 4'd8;

   // Datapath sizes
   localparam int DIFF_W    = PHASE_W - 1;          // phase - interval, at most 1.0
   localparam int Q_W       = 25;                   // quotient, at most 1.0 in UQ.24
   localparam int DIV_STEPS = Q_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int REM_W     = SMOOTH_W;
   localparam int TRIAL_W   = REM_W + 2;
   localparam int MUL_A_W   = (W_W > FREQ_W + 1) ? W_W : FREQ_W + 1;
   localparam int MUL_B_W   = SCALE_W + 1;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int STEP_W    = FREQ_W + SCALE_W - 8;
   localparam int JPROD_W   = Q_W + D2_W;

   localparam logic [Q_W-1:0]       T_ONE      = Q_W'(ONE_PHASE);
   localparam logic [JPROD_W-1:0]   J_HALF     = JPROD_W'(1) << 23;
   localparam logic [D2_W-1:0]      J_MAX      = D2_W'(D2);
   localparam logic [D2_W-1:0]      J_MID      = D2_W'(COS_TABLE_DEPTH);
   localparam logic signed [SUM_W-1:0] ROUND_TERM = SUM_W'(1) << FRAC_BITS;
   localparam logic signed [SUM_W-1:0] SAT_MAX    = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0] SAT_MIN    = -SUM_W'(32768);

   // Registers
   logic [ST_W-1:0]              state_ff, state_in;
   logic [FREQ_W-1:0]            nyq_ff, nyq_in;
   logic [SCALE_W-1:0]           scale_ff, scale_in;
   logic [FREQ_W-1:0]            freq_ff, freq_in;
   logic [SMOOTH_W-1:0]          smooth_ff, smooth_in;
   logic signed [LEVEL_W-1:0]    rand_a_ff, rand_a_in;
   logic [PHASE_W-1:0]           phase_ff, phase_in;
   logic signed [LEVEL_W-1:0]    lvl_old_ff, lvl_old_in;
   logic signed [LEVEL_W-1:0]    lvl_new_ff, lvl_new_in;
   logic [REM_W-1:0]             rem_ff, rem_in;
   logic [Q_W-1:0]               num_ff, num_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [ROM_AW-1:0]            rom_addr_ff, rom_addr_in;
   logic                         neg_ff, neg_in;
   logic [SAMPLE_BITS-1:0]       rom_data_ff;
   logic signed [W_W-1:0]        w_ff, w_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [OUT_W-1:0]      sample_ff, sample_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]      rsp_sample_ff, rsp_sample_in;

   // Combinational terms
   logic                         req_beat;
   logic [PHASE_W-1:0]           interval;
   logic [PHASE_W-1:0]           phase_diff;
   logic [TRIAL_W-1:0]           trial;
   logic [REM_W:0]               shifted;
   logic [Q_W-1:0]               t_clip;
   logic [JPROD_W-1:0]           jprod;
   logic [D2_W-1:0]              j_raw;
   logic [D2_W-1:0]              j_idx;
   logic signed [MUL_A_W-1:0]    mul_a;
   logic signed [MUL_B_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]     mul_prod;
   logic signed [LEVEL_W:0]      lvl_diff;
   logic signed [LEVEL_W:0]      lvl_sum;
   logic signed [SUM_W-1:0]      blend_num;
   logic signed [SUM_W-1:0]      blend_res;
   logic [STEP_W-1:0]            step;
   logic [PHASE_W-1:0]           phase_sum;

   assign req_beat      = req_if.valid && req_if.ready;
   assign req_if.ready  = (state_ff == ST_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.sample = rsp_sample_ff;

   // Segment boundaries and division setup
   assign interval   = PHASE_W'(SMOOTH_ONE - smooth_ff) << 7;
   assign phase_diff = phase_ff - interval;
   assign shifted    = {rem_ff, num_ff[Q_W-1]};
   assign trial      = {1'b0, shifted} - TRIAL_W'(smooth_ff);

   // Table index from the blend position
   assign t_clip = (num_ff > T_ONE) ? T_ONE : num_ff;
   assign jprod  = JPROD_W'(t_clip) * JPROD_W'(D2) + J_HALF;
   assign j_raw  = D2_W'(jprod >> 24);
   assign j_idx  = (j_raw > J_MAX) ? J_MAX : j_raw;

   // Shared multiplier: weight times level span, then frequency times step scale
   assign lvl_diff = {lvl_new_ff[LEVEL_W-1], lvl_new_ff} - {lvl_old_ff[LEVEL_W-1], lvl_old_ff};
   assign lvl_sum  = {lvl_new_ff[LEVEL_W-1], lvl_new_ff} + {lvl_old_ff[LEVEL_W-1], lvl_old_ff};

   always_comb begin
      if (state_ff == ST_MULW) begin
         mul_a = MUL_A_W'(w_ff);
         mul_b = MUL_B_W'(lvl_diff);
      end else begin
         mul_a = MUL_A_W'({1'b0, freq_ff});
         mul_b = MUL_B_W'({1'b0, scale_ff});
      end
   end

   assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Blend: floor((w*span + sum*2^F + 2^F) / 2^(F+1)), then saturate
   assign blend_num = SUM_W'(prod_ff) + (SUM_W'(lvl_sum) <<< FRAC_BITS) + ROUND_TERM;
   assign blend_res = blend_num >>> (FRAC_BITS + 1);

   // Phase advance with saturation at the top of the accumulator
   assign step      = STEP_W'(prod_ff >>> 8);
   assign phase_sum = (step >= STEP_W'(PHASE_MAX - phase_ff)) ? PHASE_MAX
                    : phase_ff + PHASE_W'(step);

   // Sequencer and datapath next values
   always_comb begin
      state_in      = state_ff;
      nyq_in        = nyq_ff;
      scale_in      = scale_ff;
      freq_in       = freq_ff;
      smooth_in     = smooth_ff;
      rand_a_in     = rand_a_ff;
      phase_in      = phase_ff;
      lvl_old_in    = lvl_old_ff;
      lvl_new_in    = lvl_new_ff;
      rem_in        = rem_ff;
      num_in        = num_ff;
      cnt_in        = cnt_ff;
      rom_addr_in   = rom_addr_ff;
      neg_in        = neg_ff;
      w_in          = w_ff;
      prod_in       = prod_ff;
      sample_in     = sample_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;

      // Drop the result once the sink takes it
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes; unknown indexes fall through
      if (csr_wr_en) begin
         case (csr_index)
            CSR_NYQUIST:    nyq_in   = csr_wdata[FREQ_W-1:0];
            CSR_STEP_SCALE: scale_in = csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (req_if.cmd == CMD_NOTE_ON) begin
                  lvl_old_in = req_if.random_a;
                  lvl_new_in = req_if.random_b;
                  phase_in   = '0;
               end else begin
                  freq_in   = (req_if.freq_hz > nyq_ff) ? nyq_ff : req_if.freq_hz;
                  smooth_in = (req_if.smoothness > SMOOTH_ONE) ? SMOOTH_ONE
                            : req_if.smoothness;
                  rand_a_in = req_if.random_a;
                  state_in  = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            // Hold segments and the zero-smoothness midpoint skip the divider
            if (phase_ff < interval) begin
               w_in     = W_POS;
               state_in = ST_MULW;
            end else if (phase_ff > ONE_PHASE - interval) begin
               w_in     = W_NEG;
               state_in = ST_MULW;
            end else if (smooth_ff == '0) begin
               w_in     = W_POS;
               state_in = ST_MULW;
            end else begin
               rem_in   = REM_W'(phase_diff[DIFF_W-1:9]);
               num_in   = {phase_diff[8:0], 16'd0};
               cnt_in   = CNT_W'(DIV_STEPS - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // One restoring step: quotient bits shift in from the bottom
            if (!trial[TRIAL_W-1]) begin
               rem_in = trial[REM_W-1:0];
               num_in = {num_ff[Q_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[REM_W-1:0];
               num_in = {num_ff[Q_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_IDX;
            end
         end
         ST_IDX: begin
            // Fold the half cosine onto the quarter-wave table
            if (j_idx <= J_MID) begin
               rom_addr_in = ROM_AW'(j_idx);
               neg_in      = 1'b0;
            end else begin
               rom_addr_in = ROM_AW'(J_MAX - j_idx);
               neg_in      = 1'b1;
            end
            state_in = ST_ROM;
         end
         ST_ROM: begin
            state_in = ST_WSEL;
         end
         ST_WSEL: begin
            w_in     = neg_ff ? -W_W'({1'b0, rom_data_ff}) : W_W'({1'b0, rom_data_ff});
            state_in = ST_MULW;
         end
         ST_MULW: begin
            prod_in  = mul_prod;
            state_in = ST_MULS;
         end
         ST_MULS: begin
            if (blend_res > SAT_MAX) begin
               sample_in = OUT_W'(SAT_MAX);
            end else if (blend_res < SAT_MIN) begin
               sample_in = OUT_W'(SAT_MIN);
            end else begin
               sample_in = OUT_W'(blend_res);
            end
            prod_in  = mul_prod;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // Hand off the sample once the output register is free, advance the phase
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sample_ff;
               if (phase_sum > ONE_PHASE) begin
                  phase_in   = phase_sum - ONE_PHASE;
                  lvl_old_in = lvl_new_ff;
                  lvl_new_in = rand_a_ff;
               end else begin
                  phase_in = phase_sum;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and oscillator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nyq_ff       <= NYQUIST_RESET;
         scale_ff     <= SCALE_RESET;
         phase_ff     <= '0;
         lvl_old_ff   <= '0;
         lvl_new_ff   <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nyq_ff       <= nyq_in;
         scale_ff     <= scale_in;
         phase_ff     <= phase_in;
         lvl_old_ff   <= lvl_old_in;
         lvl_new_ff   <= lvl_new_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      freq_ff       <= freq_in;
      smooth_ff     <= smooth_in;
      rand_a_ff     <= rand_a_in;
      rem_ff        <= rem_in;
      num_ff        <= num_in;
      rom_addr_ff   <= rom_addr_in;
      neg_ff        <= neg_in;
      w_ff          <= w_in;
      prod_ff       <= prod_in;
      sample_ff     <= sample_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   // Cosine table, registered read
   always_ff @(posedge clock) begin
      rom_data_ff <= COS_ROM[rom_addr_ff];
   end

   // Note-on clears the phase on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_beat && (req_if.cmd == CMD_NOTE_ON)) |=> (phase_ff == '0))
      else $error("phase not cleared after note-on beat");

   // The division result never exceeds 1.0
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDX) |-> (num_ff <= T_ONE))
      else $error("blend position above 1.0");

   // The weight stays within -1..+1 when it enters the multiplier
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULW) |-> ((w_ff <= W_POS) && (w_ff >= W_NEG)))
      else $error("blend weight out of range");

   // A tick beat leaves idle for prep; the result on the way back is not checked here
   assert property (@(posedge clock) disable iff (reset)
      (req_beat && (req_if.cmd == CMD_TICK)) |=> (state_ff == ST_PREP))
      else $error("tick beat did not start the sequencer");

endmodule
